### sv/assert_macros.svh
// Assertion helpers, clocked on the rising edge, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");

`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("property violated");

`endif

### sv/tusa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tusa_pkg;

  localparam int FIRST_UNIT_DEF  = 8;
  localparam int SLOT_COUNT_DEF  = 32;
  localparam int TEXTURE_IDS_DEF = 256;

  localparam int ID_W   = 8;
  localparam int UNIT_W = 6;
  localparam int CNT_W  = 32;

  localparam logic OP_BIND  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

endpackage
`default_nettype wire

### sv/tusa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tusa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/texture_unit_slot_allocator.sv
// Flow: a flush or null bind gives its result in the cycle after accept; a bind
//   steps S_SCAN through the slots to a hit or the last slot, then S_WRITE on a
//   miss (skipped when all are locked) and S_REPLY, which waits for the output.
// Throughput: one bind at a time, set by the single slot compare unit stepping
//   through the slots; flush/null one per cycle while the output is not stalled.
// Reset: synchronous; slots empty and unlocked, then each bind count RAM entry is cleared in turn with in_ready low.
`timescale 1ns / 1ps
`default_nettype none
module texture_unit_slot_allocator #(
  parameter int FIRST_UNIT  = tusa_pkg::FIRST_UNIT_DEF,
  parameter int SLOT_COUNT  = tusa_pkg::SLOT_COUNT_DEF,
  parameter int TEXTURE_IDS = tusa_pkg::TEXTURE_IDS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      operation,
  input  wire logic [tusa_pkg::ID_W-1:0] texture_id,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [tusa_pkg::UNIT_W-1:0]    unit,
  output logic                           hit,
  output logic                           no_slot
);

  import tusa_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IDX_W  = $clog2(TEXTURE_IDS);
  localparam int IDS_IN = 1 << ID_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_REPLY
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   clr_addr;
  logic [SLOT_W-1:0]  scan;
  logic [ID_W-1:0]    cur_id;
  logic [ID_W-1:0]    slot_texture [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_locked;
  logic [CNT_W-1:0]   slot_cnt [SLOT_COUNT];
  logic               found;
  logic               empty_found;
  logic [SLOT_W-1:0]  chosen;
  logic [CNT_W-1:0]   best;
  logic [UNIT_W-1:0]  res_unit;
  logic               res_hit;
  logic               res_no_slot;

  logic [IDX_W-1:0]   idx_tab [IDS_IN];

  logic               accept;
  logic               out_free;
  logic               reply_load;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;
  logic [CNT_W-1:0]   ram_rdata;
  logic [CNT_W-1:0]   cnt_inc;
  logic [ID_W-1:0]    s_tex;
  logic               s_lock;
  logic [CNT_W-1:0]   s_cnt;
  logic               s_empty;
  logic               hit_now;
  logic               take;
  logic               last;

  // id modulo table size, worked out at elaboration
  for (genvar g = 0; g < IDS_IN; g++) begin : g_idx
    assign idx_tab[g] = IDX_W'(g % TEXTURE_IDS);
  end

  function automatic logic [UNIT_W-1:0] unit_of(input logic [SLOT_W-1:0] s);
    logic [UNIT_W+1:0] sum;
    sum = (UNIT_W+2)'(FIRST_UNIT) + (UNIT_W+2)'(s);
    return sum[UNIT_W-1:0];
  endfunction

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign reply_load = (accept && (operation == OP_FLUSH || texture_id == '0)) ||
                      ((state == S_REPLY) && out_free);

  assign s_tex   = slot_texture[scan];
  assign s_lock  = slot_locked[scan];
  assign s_cnt   = slot_cnt[scan];
  assign s_empty = (s_tex == '0);
  assign hit_now = (s_tex == cur_id);
  assign last    = (scan == SLOT_W'(SLOT_COUNT - 1));
  assign take    = !s_lock && !empty_found && (s_empty || !found || (s_cnt < best));

  assign cnt_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1);
  assign ram_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : idx_tab[cur_id];
  assign ram_wdata = (state == S_CLEAR) ? '0 : cnt_inc;

  tusa_ram #(
    .WIDTH(CNT_W),
    .DEPTH(TEXTURE_IDS)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(idx_tab[texture_id]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      scan        <= '0;
      slot_locked <= '0;
      found       <= 1'b0;
      empty_found <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_texture[i] <= '0;
      end
    end else begin
      if (reply_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(TEXTURE_IDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur_id      <= texture_id;
            scan        <= '0;
            found       <= 1'b0;
            empty_found <= 1'b0;
            if (operation == OP_FLUSH || texture_id == '0) begin
              if (operation == OP_FLUSH) begin
                slot_locked <= '0;
              end
              unit      <= '0;
              hit       <= 1'b0;
              no_slot   <= 1'b0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan <= scan + SLOT_W'(1);
          if (take) begin
            chosen <= scan;
            best   <= s_cnt;
            found  <= 1'b1;
            if (s_empty) begin
              empty_found <= 1'b1;
            end
          end
          if (hit_now) begin
            res_unit    <= unit_of(scan);
            res_hit     <= 1'b1;
            res_no_slot <= 1'b0;
            state       <= S_REPLY;
          end else if (last) begin
            if (found || take) begin
              state <= S_WRITE;
            end else begin
              res_unit    <= '0;
              res_hit     <= 1'b0;
              res_no_slot <= 1'b1;
              state       <= S_REPLY;
            end
          end
        end
        S_WRITE: begin
          // resident ids sharing the count entry see the new count too
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (SLOT_W'(i) == chosen || idx_tab[slot_texture[i]] == idx_tab[cur_id]) begin
              slot_cnt[i] <= cnt_inc;
            end
          end
          slot_texture[chosen] <= cur_id;
          slot_locked[chosen]  <= 1'b1;
          res_unit             <= unit_of(chosen);
          res_hit              <= 1'b0;
          res_no_slot          <= 1'b0;
          state                <= S_REPLY;
        end
        S_REPLY: begin
          if (out_free) begin
            unit      <= res_unit;
            hit       <= res_hit;
            no_slot   <= res_no_slot;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/tusa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tusa_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        operation,
  input wire logic [tusa_pkg::ID_W-1:0]   texture_id,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tusa_pkg::UNIT_W-1:0] unit,
  input wire logic                        hit,
  input wire logic                        no_slot
);

  import tusa_pkg::*;

  // stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
               out_valid && $stable(unit) && $stable(hit) && $stable(no_slot))
  // failure word carries no unit and no hit
  `ASSERT_IMPL(a_no_slot_clean, clk, rst, out_valid && no_slot |-> unit == '0 && !hit)
  // flush or null bind answers in the next cycle with an all-zero word
  `ASSERT_NEXT(a_quick_reply, clk, rst,
               in_valid && in_ready && (operation == OP_FLUSH || texture_id == '0),
               out_valid && unit == '0 && !hit && !no_slot)
  // a real bind occupies the block
  `ASSERT_NEXT(a_bind_busy, clk, rst,
               in_valid && in_ready && operation == OP_BIND && texture_id != '0,
               !in_ready)

endmodule

bind texture_unit_slot_allocator tusa_checker u_tusa_checker (.*);
`default_nettype wire
